// ===== design/ctc_pkg.sv =====
// shared types and constants for the click type classifier
`timescale 1ns / 1ps
package ctc_pkg;

  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam int EVT_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX      = 8'd3;

  // register reset values
  localparam logic [CNT_W-1:0] FILTER_TICKS_RST = 16'd200;
  localparam logic [CNT_W-1:0] LONG_LIMIT_RST   = 16'd1800;
  localparam logic [CNT_W-1:0] GAP_MIN_RST      = 16'd150;
  localparam logic [CNT_W-1:0] GAP_MAX_RST      = 16'd1500;

  // event codes
  localparam logic [EVT_W-1:0] EVT_NONE   = 2'd0;
  localparam logic [EVT_W-1:0] EVT_SINGLE = 2'd1;
  localparam logic [EVT_W-1:0] EVT_DOUBLE = 2'd2;
  localparam logic [EVT_W-1:0] EVT_LONG   = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] filter_ticks;
    logic [CNT_W-1:0] long_limit;
    logic [CNT_W-1:0] gap_min;
    logic [CNT_W-1:0] gap_max;
  } ctc_cfg_t;

endpackage

// ===== design/ctc_cfg.sv =====
// configuration register bank for the click type classifier
`timescale 1ns / 1ps
module ctc_cfg
  import ctc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output ctc_cfg_t             cfg
);

  // write port, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_ticks <= FILTER_TICKS_RST;
      cfg.long_limit   <= LONG_LIMIT_RST;
      cfg.gap_min      <= GAP_MIN_RST;
      cfg.gap_max      <= GAP_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_TICKS: cfg.filter_ticks <= cfg_data;
        REG_LONG_LIMIT:   cfg.long_limit   <= cfg_data;
        REG_GAP_MIN:      cfg.gap_min      <= cfg_data;
        REG_GAP_MAX:      cfg.gap_max      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ctc_core.sv =====
// classifier state and per-tick update logic
`timescale 1ns / 1ps
module ctc_core
  import ctc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             released,
  input  ctc_cfg_t         cfg,
  output logic [EVT_W-1:0] event_code
);

  logic             pressed_seen, pressed_seen_next;
  logic             recognised, recognised_next;
  logic [CNT_W-1:0] hold_prescale, hold_prescale_next;
  logic [CNT_W-1:0] gap_prescale, gap_prescale_next;
  logic [CNT_W-1:0] hold_units, hold_units_next;
  logic [CNT_W-1:0] gap_units, gap_units_next;

  // one tick of the classifier
  always_comb begin
    pressed_seen_next  = pressed_seen;
    recognised_next    = recognised;
    hold_prescale_next = hold_prescale;
    gap_prescale_next  = gap_prescale;
    hold_units_next    = hold_units;
    gap_units_next     = gap_units;
    event_code         = EVT_NONE;

    // clear after a report, leave the wait on release
    if (recognised) begin
      pressed_seen_next  = 1'b0;
      hold_prescale_next = '0;
      gap_prescale_next  = '0;
      hold_units_next    = '0;
      gap_units_next     = '0;
      if (released) recognised_next = 1'b0;
    end

    // hold counting while pressed
    if (!released && !recognised_next) begin
      pressed_seen_next  = 1'b1;
      hold_prescale_next = hold_prescale_next + 1'b1;
      if (hold_prescale_next > cfg.filter_ticks) begin
        hold_prescale_next = '0;
        hold_units_next    = hold_units_next + 1'b1;
      end
    end

    if (hold_units_next > cfg.long_limit) begin
      recognised_next = 1'b1;
      event_code      = EVT_LONG;
    end else begin
      // gap counting while released after a press
      if (pressed_seen_next && released) begin
        gap_prescale_next = gap_prescale_next + 1'b1;
        if (gap_prescale_next > cfg.filter_ticks) begin
          gap_prescale_next = '0;
          gap_units_next    = gap_units_next + 1'b1;
        end
      end
      // double inside the window, single beyond it
      if (pressed_seen_next && gap_units_next > cfg.gap_min &&
          gap_units_next < cfg.gap_max) begin
        if (!released) begin
          recognised_next = 1'b1;
          event_code      = EVT_DOUBLE;
        end
      end else if (pressed_seen_next && gap_units_next > cfg.gap_max) begin
        recognised_next = 1'b1;
        event_code      = EVT_SINGLE;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_seen  <= 1'b0;
      recognised    <= 1'b0;
      hold_prescale <= '0;
      gap_prescale  <= '0;
      hold_units    <= '0;
      gap_units     <= '0;
    end else if (step) begin
      pressed_seen  <= pressed_seen_next;
      recognised    <= recognised_next;
      hold_prescale <= hold_prescale_next;
      gap_prescale  <= gap_prescale_next;
      hold_units    <= hold_units_next;
      gap_units     <= gap_units_next;
    end
  end

`ifndef ASSERT_OFF
  // any report arms the wait on release
  a_report_arms: assert property (@(posedge clk) disable iff (rst)
    step && event_code != EVT_NONE |=> recognised)
    else $error("report without recognised state");

  // a press while waiting keeps everything cleared
  a_wait_clears: assert property (@(posedge clk) disable iff (rst)
    step && recognised && !released |=>
      recognised && !pressed_seen && hold_units == '0 && gap_units == '0)
    else $error("counters not cleared while waiting for release");

  // a counted press marks the press seen
  a_press_seen: assert property (@(posedge clk) disable iff (rst)
    step && !recognised && !released |=> pressed_seen || recognised)
    else $error("press not recorded");
`endif

endmodule

// ===== design/click_type_classifier.sv =====
// top level of the click type classifier: input and result registers
//
//   channel  signals                        direction  word
//   in       in_valid in_ready key_level     in         one scan tick
//   out      out_valid out_ready click_event out        one event code
//   cfg      cfg_we cfg_index cfg_data       in         one register write
//
// one tick per cycle sustained while out_ready holds; a tick is held in the input register
// and its event, worked out from it by the classifier, is registered in the result register.
// the classifier update is one pass of compare-and-count logic per tick.
// rst clears the handshake, the classifier state and the registers to defaults.
// a stalled result holds while the input register keeps one more tick.
`timescale 1ns / 1ps
module click_type_classifier
  import ctc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 key_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EVT_W-1:0]     click_event,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  ctc_cfg_t         cfg;
  logic             tick_valid;
  logic             tick_key;
  logic             advance;
  logic [EVT_W-1:0] event_code;

  ctc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // tick moves on when the result register is free or draining
  assign advance  = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) tick_key <= key_level;
  end

  ctc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .released   (tick_key),
    .cfg        (cfg),
    .event_code (event_code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) click_event <= event_code;
  end

endmodule
